### design/gmupc_pkg.sv
// Shared widths and the cell classification word for the grid uphill path cost block.
`timescale 1ns / 1ps
`default_nettype none
package gmupc_pkg;

	localparam int COST_W = 32;
	localparam int OUT_W = 31;
	localparam int SIDE_CFG_W = 11;

	localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};
	localparam logic [OUT_W-1:0] OUT_SAT = {OUT_W{1'b1}};

	// Position of a cell in its grid, decided at the front.
	typedef struct packed {
		logic top_row;
		logic left_col;
		logic last_cell;
	} cell_kind_t;

endpackage
`default_nettype wire

### design/gmupc_front.sv
// Front part: accepts cell heights, tracks row and column, classifies each cell.
`timescale 1ns / 1ps
`default_nettype none
module gmupc_front #(
	parameter int MAX_SIDE = 1024,
	parameter int HEIGHT_BITS = 20,
	parameter int COL_W = 10
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	input  wire logic [gmupc_pkg::SIDE_CFG_W-1:0]     grid_side,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [HEIGHT_BITS-1:0]               height,
	output logic                                      push_valid,
	input  wire logic                                 push_ready,
	output logic [HEIGHT_BITS-1:0]                    push_height,
	output logic [COL_W-1:0]                          push_col,
	output gmupc_pkg::cell_kind_t                     push_kind
);

	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic [COL_W-1:0] side_m1_q;
	logic [31:0]      gs32;
	logic [COL_W-1:0] side_m1_new;
	logic             push;
	logic             col_end;

	// Clamp the written side into [2, MAX_SIDE] and keep side minus one.
	always_comb begin
		gs32 = 32'(grid_side);
		if (gs32 < 32'd2) begin
			side_m1_new = COL_W'(1);
		end else if (gs32 > 32'(MAX_SIDE)) begin
			side_m1_new = COL_W'(MAX_SIDE - 1);
		end else begin
			side_m1_new = COL_W'(gs32 - 32'd1);
		end
	end

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign push = in_valid && push_ready;
	assign push_height = height;
	assign push_col = col_q;
	assign col_end = (col_q == side_m1_q);

	always_comb begin
		push_kind.top_row = (row_q == '0);
		push_kind.left_col = (col_q == '0);
		push_kind.last_cell = col_end && (row_q == side_m1_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			side_m1_q <= COL_W'(1);
		end else if (cfg_valid) begin
			col_q <= '0;
			row_q <= '0;
			side_m1_q <= side_m1_new;
		end else if (push) begin
			if (push_kind.last_cell) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + COL_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### design/gmupc_queue.sv
// Two-entry queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module gmupc_queue #(
	parameter int W = 33
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);

	logic [W-1:0] ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         push;
	logic         pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = ent_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### design/gmupc_back.sv
// Back part: row buffer read-modify-write, cost update and result register.
`timescale 1ns / 1ps
`default_nettype none
module gmupc_back #(
	parameter int MAX_SIDE = 1024,
	parameter int HEIGHT_BITS = 20,
	parameter int COL_W = 10
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pop_valid,
	output logic                                  pop_ready,
	input  wire logic [HEIGHT_BITS-1:0]           pop_height,
	input  wire logic [COL_W-1:0]                 pop_col,
	input  wire gmupc_pkg::cell_kind_t            pop_kind,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [gmupc_pkg::OUT_W-1:0]           min_cost
);

	localparam int CW = gmupc_pkg::COST_W;
	localparam int MW = CW + HEIGHT_BITS;

	logic [MW-1:0]          row_mem [MAX_SIDE];
	logic [MW-1:0]          rd_q;
	logic                   s1_valid_q;
	logic [HEIGHT_BITS-1:0] height_s1;
	logic [COL_W-1:0]       col_s1;
	gmupc_pkg::cell_kind_t  kind_s1;
	logic [CW-1:0]          left_cost_q;
	logic [HEIGHT_BITS-1:0] left_h_q;
	logic                   out_valid_q;
	logic [gmupc_pkg::OUT_W-1:0] min_cost_q;
	logic                   pop;
	logic                   s1_fire;
	logic [CW-1:0]          up_cost;
	logic [CW-1:0]          lf_cost;
	logic [CW-1:0]          cost;
	logic [gmupc_pkg::OUT_W-1:0] cost_out;

	function automatic logic [CW-1:0] climb(
		input logic [CW-1:0]          base,
		input logic [HEIGHT_BITS-1:0] from_h,
		input logic [HEIGHT_BITS-1:0] to_h
	);
		logic [CW:0] rise;
		logic [CW:0] sum;
		begin
			rise = (to_h > from_h) ? (CW+1)'(to_h - from_h) : '0;
			sum = {1'b0, base} + rise;
			climb = sum[CW] ? gmupc_pkg::COST_SAT : sum[CW-1:0];
		end
	endfunction

	// Retire the cell unless its result has nowhere to go.
	assign s1_fire = s1_valid_q && (!kind_s1.last_cell || !out_valid_q || out_ready);
	assign pop = pop_valid && (!s1_valid_q || s1_fire);
	assign pop_ready = (!s1_valid_q || s1_fire);

	always_comb begin
		up_cost = climb(rd_q[MW-1:HEIGHT_BITS], rd_q[HEIGHT_BITS-1:0], height_s1);
		lf_cost = climb(left_cost_q, left_h_q, height_s1);
		if (kind_s1.top_row && kind_s1.left_col) begin
			cost = '0;
		end else if (kind_s1.top_row) begin
			cost = lf_cost;
		end else if (kind_s1.left_col) begin
			cost = up_cost;
		end else begin
			cost = (up_cost < lf_cost) ? up_cost : lf_cost;
		end
		cost_out = cost[CW-1] ? gmupc_pkg::OUT_SAT : cost[gmupc_pkg::OUT_W-1:0];
	end

	// Consecutive cells of one grid never share a column, so their read and write never collide.
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= row_mem[pop_col];
		end
		if (s1_fire) begin
			row_mem[col_s1] <= {cost, height_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			height_s1 <= pop_height;
			col_s1 <= pop_col;
			kind_s1 <= pop_kind;
		end
		if (s1_fire && kind_s1.last_cell) begin
			min_cost_q <= cost_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			left_cost_q <= '0;
			left_h_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_fire) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				left_cost_q <= cost;
				left_h_q <= height_s1;
			end
			if (s1_fire && kind_s1.last_cell) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign min_cost = min_cost_q;

endmodule
`default_nettype wire

### design/grid_min_uphill_path_cost.sv
// Top level: least uphill climb over right/down paths of a square height grid.
//
//  channel | signals                         | word
//  --------+---------------------------------+------------------------------
//  cfg     | cfg_valid, cfg_ready, grid_side | grid side, 11 bits
//  in      | in_valid, in_ready, height      | one cell height, raster order
//  out     | out_valid, out_ready, min_cost  | min climb, once per grid
//
// One cell per cycle unless stalled; a cell does one row buffer read and write.
// A last cell passes the queue and stage 1, then its result is registered.
// Reset returns to the first cell of a grid of side 2; no clearing pass is run,
// since the top row of every grid writes the row buffer before it is read.
// A waiting result stalls only a following last cell and the cells behind it.
`timescale 1ns / 1ps
`default_nettype none
module grid_min_uphill_path_cost #(
	parameter int MAX_SIDE = 1024,
	parameter int HEIGHT_BITS = 20
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [gmupc_pkg::SIDE_CFG_W-1:0]   grid_side,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [HEIGHT_BITS-1:0]             height,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [gmupc_pkg::OUT_W-1:0]             min_cost
);

	localparam int COL_W = $clog2(MAX_SIDE);
	localparam int KIND_W = $bits(gmupc_pkg::cell_kind_t);
	localparam int QW = KIND_W + COL_W + HEIGHT_BITS;

	logic                   push_valid;
	logic                   push_ready;
	logic [HEIGHT_BITS-1:0] push_height;
	logic [COL_W-1:0]       push_col;
	gmupc_pkg::cell_kind_t  push_kind;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [QW-1:0]          pop_data;
	gmupc_pkg::cell_kind_t  pop_kind;

	assign cfg_ready = 1'b1;
	assign pop_kind = pop_data[QW-1:COL_W+HEIGHT_BITS];

	gmupc_front #(
		.MAX_SIDE(MAX_SIDE),
		.HEIGHT_BITS(HEIGHT_BITS),
		.COL_W(COL_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.grid_side(grid_side),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.height(height),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_height(push_height),
		.push_col(push_col),
		.push_kind(push_kind)
	);

	gmupc_queue #(
		.W(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data({push_kind, push_col, push_height}),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	gmupc_back #(
		.MAX_SIDE(MAX_SIDE),
		.HEIGHT_BITS(HEIGHT_BITS),
		.COL_W(COL_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_height(pop_data[HEIGHT_BITS-1:0]),
		.pop_col(pop_data[COL_W+HEIGHT_BITS-1:HEIGHT_BITS]),
		.pop_kind(pop_kind),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost(min_cost)
	);

endmodule
`default_nettype wire

### verif/uphill_cost_monitor.sv
// Channel monitor for the uphill path cost block: predicts each grid minimum and checks results.
`timescale 1ns / 1ps
module uphill_cost_monitor (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	input  wire logic                         cfg_ready,
	input  wire logic [gmupc_pkg::SIDE_CFG_W-1:0] grid_side,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic [19:0]                  height,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [gmupc_pkg::OUT_W-1:0]  min_cost,
	output int                                fail_count,
	output int                                results_owed
);

	localparam int COST_W = gmupc_pkg::COST_W;
	localparam int OUT_W = gmupc_pkg::OUT_W;
	localparam int SIDE_CFG_W = gmupc_pkg::SIDE_CFG_W;
	localparam logic [COST_W-1:0] COST_SAT = gmupc_pkg::COST_SAT;
	localparam logic [OUT_W-1:0] OUT_SAT = gmupc_pkg::OUT_SAT;
	localparam int SIDE_LIMIT = 1024;
	localparam int HEIGHT_W = 20;
	localparam int REPORT_LIMIT = 10;

	logic [COST_W-1:0]   cost_row [SIDE_LIMIT];
	logic [HEIGHT_W-1:0] height_row [SIDE_LIMIT];
	logic [COST_W-1:0]   left_cost;
	logic [HEIGHT_W-1:0] left_height;
	logic [9:0]          col_idx;
	logic [9:0]          row_idx;
	logic [SIDE_CFG_W-1:0] side_cfg;

	logic [OUT_W-1:0] min_cost_due [$];
	int bad_words;

	assign fail_count = bad_words;

	function automatic logic [SIDE_CFG_W-1:0] active_side(input logic [SIDE_CFG_W-1:0] v);
		if (v < 2)
			return SIDE_CFG_W'(2);
		if (v > SIDE_LIMIT)
			return SIDE_CFG_W'(SIDE_LIMIT);
		return v;
	endfunction

	// Add the rise into the next cell, saturating at the cost width.
	function automatic logic [COST_W-1:0] climb(input logic [COST_W-1:0] base,
			input logic [HEIGHT_W-1:0] from_h, input logic [HEIGHT_W-1:0] to_h);
		logic [COST_W:0] sum;
		logic [HEIGHT_W-1:0] rise;
		rise = (to_h > from_h) ? to_h - from_h : '0;
		sum = {1'b0, base} + (COST_W+1)'(rise);
		return (sum > {1'b0, COST_SAT}) ? COST_SAT : sum[COST_W-1:0];
	endfunction

	task automatic advance_cell(input logic [HEIGHT_W-1:0] h);
		logic [SIDE_CFG_W-1:0] side;
		logic [SIDE_CFG_W-1:0] c;
		logic [SIDE_CFG_W-1:0] r;
		logic [COST_W-1:0] cost;
		logic [COST_W-1:0] via_up;
		logic [COST_W-1:0] via_left;
		side = active_side(side_cfg);
		c = {1'b0, col_idx};
		r = {1'b0, row_idx};
		if (c >= side)
			c = '0;
		if (r >= side)
			r = '0;
		via_up = climb(cost_row[c[9:0]], height_row[c[9:0]], h);
		via_left = climb(left_cost, left_height, h);
		if (r == 0 && c == 0)
			cost = '0;
		else if (r == 0)
			cost = via_left;
		else if (c == 0)
			cost = via_up;
		else
			cost = (via_up < via_left) ? via_up : via_left;
		cost_row[c[9:0]] = cost;
		height_row[c[9:0]] = h;
		left_cost = cost;
		left_height = h;
		if (r == side - 1 && c == side - 1) begin
			min_cost_due.push_back(({1'b0, cost} > {2'b0, OUT_SAT}) ? OUT_SAT : cost[OUT_W-1:0]);
			col_idx = '0;
			row_idx = '0;
		end else if (c + 1 >= side) begin
			col_idx = '0;
			row_idx = r[9:0] + 10'd1;
		end else begin
			col_idx = c[9:0] + 10'd1;
			row_idx = r[9:0];
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE_LIMIT; i++) begin
				cost_row[i] = '0;
				height_row[i] = '0;
			end
			left_cost = '0;
			left_height = '0;
			col_idx = '0;
			row_idx = '0;
			side_cfg = SIDE_CFG_W'(2);
			min_cost_due.delete();
			bad_words = 0;
			results_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				side_cfg = grid_side;
				col_idx = '0;
				row_idx = '0;
			end
			// Check the word leaving before queueing any new minimum from this edge.
			if (out_valid && out_ready) begin
				if (min_cost_due.size() == 0) begin
					if (bad_words < REPORT_LIMIT)
						$display("%0t: min_cost %0d arrived with no grid outstanding", $time,
							min_cost);
					bad_words++;
				end else begin
					if (min_cost !== min_cost_due[0]) begin
						if (bad_words < REPORT_LIMIT)
							$display("%0t: min_cost expected %0d, got %0d", $time,
								min_cost_due[0], min_cost);
						bad_words++;
					end
					void'(min_cost_due.pop_front());
				end
			end
			if (in_valid && in_ready)
				advance_cell(height);
			results_owed <= min_cost_due.size();
		end
	end

endmodule

### verif/grid_min_uphill_path_cost_test.sv
// Stimulus and verdict for the uphill path cost block: grids of many sides under random flow control.
`timescale 1ns / 1ps
module grid_min_uphill_path_cost_test;

	localparam int SIDE_CFG_W = gmupc_pkg::SIDE_CFG_W;
	localparam int OUT_W = gmupc_pkg::OUT_W;
	localparam int HEIGHT_W = 20;
	localparam int SIDE_LIMIT = 1024;
	localparam logic [HEIGHT_W-1:0] H_TOP = '1;

	typedef enum int {FILL_RANDOM, FILL_SHALLOW, FILL_EXTREME, FILL_STAIRS} fill_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [SIDE_CFG_W-1:0] grid_side;
	logic in_valid;
	logic in_ready;
	logic [HEIGHT_W-1:0] height;
	logic out_valid;
	logic out_ready;
	logic [OUT_W-1:0] min_cost;

	int fail_count;
	int results_owed;
	int cells_sent;
	int grids_done;
	bit no_gaps;
	bit pressure_go;
	bit sink_hold;

	grid_min_uphill_path_cost dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.grid_side(grid_side),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.height(height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost(min_cost)
	);

	uphill_cost_monitor monitor (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.grid_side(grid_side),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.height(height),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.min_cost(min_cost),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int gap_draw();
		return no_gaps ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic int grid_span(input logic [SIDE_CFG_W-1:0] v);
		if (v < 2)
			return 2;
		if (v > SIDE_LIMIT)
			return SIDE_LIMIT;
		return v;
	endfunction

	// Entered at a clock step with in_valid not yet driven; returns at the accepting step.
	task automatic offer_cell(input logic [HEIGHT_W-1:0] h);
		int gap;
		gap = gap_draw();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		height <= h;
		do @(posedge clk); while (!in_ready);
		cells_sent++;
	endtask

	// Drop the input and wait out every owed minimum plus the pipeline tail.
	task automatic drain_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_side(input logic [SIDE_CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		grid_side <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic feed_grid(input int side, input fill_t fill, input int ncells);
		logic [HEIGHT_W-1:0] h;
		for (int k = 0; k < ncells; k++) begin
			case (fill)
				FILL_RANDOM: h = HEIGHT_W'($urandom);
				FILL_SHALLOW: h = HEIGHT_W'($urandom_range(0, 7));
				FILL_EXTREME: h = $urandom_range(0, 1) ? H_TOP : '0;
				default: h = HEIGHT_W'(k * 4099);
			endcase
			offer_cell(h);
		end
		if (ncells == side * side)
			grids_done++;
	endtask

	task automatic feed_fixed(input logic [HEIGHT_W-1:0] cells[$]);
		foreach (cells[i])
			offer_cell(cells[i]);
		grids_done++;
	endtask

	// Result side: one wait draw per word taken, held low through the pressure window.
	initial begin
		int wait_left;
		wait_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				wait_left = gap_draw();
			if (sink_hold || wait_left != 0) begin
				out_ready <= 1'b0;
				if (wait_left != 0)
					wait_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Long result stall so the block backs up into its input.
	initial begin
		sink_hold = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (400) @(posedge clk);
		sink_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("grid_min_uphill_path_cost regression: fail");
		$finish;
	end

	initial begin
		int pick;
		int side;
		int n;
		logic [SIDE_CFG_W-1:0] v;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		grid_side = '0;
		in_valid = 1'b0;
		height = '0;
		no_gaps = 1'b0;
		pressure_go = 1'b0;
		cells_sent = 0;
		grids_done = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset side of two, no write yet.
		feed_fixed('{20'd0, H_TOP, H_TOP, 20'd0});
		feed_fixed('{H_TOP, 20'd0, 20'd0, H_TOP});
		// Sides below two act as two.
		drain_block();
		set_side(SIDE_CFG_W'(0));
		feed_fixed('{20'd0, 20'd10, 20'd3, 20'd4});
		drain_block();
		set_side(SIDE_CFG_W'(1));
		feed_fixed('{20'd7, 20'd1, 20'd9, 20'd2});
		drain_block();
		set_side(SIDE_CFG_W'(3));
		feed_fixed('{H_TOP, 20'd0, H_TOP, 20'd0, H_TOP, 20'd0, H_TOP, 20'd0, H_TOP});

		// Widest sides: start a grid, then abandon it by rewriting the side.
		drain_block();
		set_side(SIDE_CFG_W'(SIDE_LIMIT));
		feed_grid(SIDE_LIMIT, FILL_RANDOM, 40);
		drain_block();
		set_side('1);
		feed_grid(SIDE_LIMIT, FILL_SHALLOW, 40);

		// Back-pressure: small grids back to back while the result side stalls.
		drain_block();
		set_side(SIDE_CFG_W'(2));
		no_gaps <= 1'b1;
		pressure_go <= 1'b1;
		repeat (40)
			feed_grid(2, FILL_RANDOM, 4);

		while (cells_sent < 850 || grids_done < 40) begin
			pick = $urandom_range(0, 99);
			if (pick < 5)
				v = SIDE_CFG_W'($urandom_range(0, 1));
			else if (pick < 60)
				v = SIDE_CFG_W'($urandom_range(2, 5));
			else if (pick < 95)
				v = SIDE_CFG_W'($urandom_range(6, 12));
			else
				v = SIDE_CFG_W'($urandom_range(13, 24));
			side = grid_span(v);
			drain_block();
			set_side(v);
			no_gaps <= ($urandom_range(0, 4) == 0);
			n = $urandom_range(1, 4);
			repeat (n)
				feed_grid(side, fill_t'($urandom_range(0, 3)), side * side);
			// Leave a grid half done now and then; the next write restarts it.
			if ($urandom_range(0, 3) == 0)
				feed_grid(side, fill_t'($urandom_range(0, 3)), $urandom_range(1, side * side - 1));
		end

		drain_block();
		if (fail_count == 0)
			$display("grid_min_uphill_path_cost regression: pass");
		else
			$display("grid_min_uphill_path_cost regression: fail");
		$finish;
	end

endmodule
